// ===== design/stis_pkg.sv =====
// Shared constants and controller/datapath interface types for the radix symbol converter.
`timescale 1ns / 1ps

package stis_pkg;

  // Table geometry
  localparam int MAX_RADIX   = 56;
  localparam int SYM_WORDS   = 7;
  localparam int RADIX_W     = 6;
  localparam int SYM_W       = 8;
  localparam int VALUE_W     = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int STACK_DEPTH = 32;
  localparam int STACK_IDX_W = 5;
  localparam int COUNT_W     = 6;

  // Special characters
  localparam logic [SYM_W-1:0] PLUS_CHAR  = 8'h2B;
  localparam logic [SYM_W-1:0] MINUS_CHAR = 8'h2D;
  localparam logic [SYM_W-1:0] LOW_CTRL   = 8'd31;
  localparam logic [SYM_W-1:0] DEL_CHAR   = 8'd127;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIX = 3'd0;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic chk_start;
    logic chk_step;
    logic load;
    logic div_step;
    logic emit_en;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic cfg_pending;
    logic chk_last;
    logic base_ok;
    logic div_last;
    logic emit_last;
  } stat_t;

endpackage

// ===== design/stis_ctrl.sv =====
// Controller state machine: table check, digit division and symbol emission phases.
`timescale 1ns / 1ps

module stis_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  stis_pkg::stat_t stat,
  output stis_pkg::cmd_t  cmd
);
  import stis_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (stat.cfg_pending) begin
          cmd.chk_start = 1'b1;
          state_next    = S_CHECK;
        end else begin
          in_stall = 1'b0;
          // An item on an invalid base is simply dropped.
          if (in_valid && stat.base_ok) begin
            cmd.load   = 1'b1;
            state_next = S_DIV;
          end
        end
      end
      S_CHECK: begin
        cmd.chk_step = 1'b1;
        if (stat.chk_last) state_next = S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_en = 1'b1;
        if (stat.emit_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/stis_dp.sv =====
// Datapath: configuration registers, table checker, radix divider, digit stack and output word.
`timescale 1ns / 1ps

module stis_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [stis_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stis_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic signed [stis_pkg::VALUE_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [stis_pkg::SYM_W-1:0]          symbol,
  output logic                                last,
  input  stis_pkg::cmd_t                      cmd,
  output stis_pkg::stat_t                     stat
);
  import stis_pkg::*;

  // Configuration and check state
  logic [RADIX_W-1:0]    radix;
  logic [CFG_DATA_W-1:0] sym_words [SYM_WORDS];
  logic                  pending;
  logic                  ok;
  logic [RADIX_W-1:0]    chk_idx;
  logic [127:0]          seen;

  // Division and emission state
  logic [VALUE_W-1:0]    quo;
  logic [RADIX_W-1:0]    rem;
  logic [1:0]            bcnt;
  logic                  neg_pend;
  logic [COUNT_W-1:0]    cnt;
  logic [RADIX_W-1:0]    stack [STACK_DEPTH];

  // Combinational values
  logic [VALUE_W-1:0]    vin;
  logic [VALUE_W-1:0]    mag;
  logic [COUNT_W-1:0]    cnt_m1;
  logic [RADIX_W-1:0]    rd_idx;
  logic [2:0]            rd_word;
  logic [CFG_DATA_W-1:0] rd_data;
  logic [SYM_W-1:0]      sym_rd;
  logic                  sym_bad;
  logic [6:0]            part;
  logic [RADIX_W-1:0]    rem_w;
  logic [7:0]            qbyte;
  logic [VALUE_W-1:0]    quo_next;
  logic                  load_ok;

  // Magnitude of the incoming value; the most negative value maps to 2^31.
  assign vin = value;
  assign mag = vin[VALUE_W-1] ? (~vin + 32'd1) : vin;

  // One symbol read port, shared by the table check and the emission phase.
  assign cnt_m1  = cnt - 6'd1;
  assign rd_idx  = cmd.emit_en ? stack[cnt_m1[STACK_IDX_W-1:0]] : chk_idx;
  assign rd_word = rd_idx[5:3];
  assign rd_data = (rd_word < 3'(SYM_WORDS)) ? sym_words[rd_word] : '0;
  assign sym_rd  = rd_data[{rd_idx[2:0], 3'b000} +: SYM_W];

  // A symbol is unusable if it is a sign, not printable, or already seen.
  assign sym_bad = (sym_rd == PLUS_CHAR) || (sym_rd == MINUS_CHAR) ||
                   (sym_rd <= LOW_CTRL) || (sym_rd >= DEL_CHAR) || seen[sym_rd[6:0]];

  // Eight restoring division steps per cycle on the top byte of the quotient.
  always_comb begin
    rem_w = rem;
    part  = '0;
    qbyte = '0;
    for (int b = 7; b >= 0; b--) begin
      part = {rem_w, quo[24+b]};
      if (part >= {1'b0, radix}) begin
        qbyte[b] = 1'b1;
        part     = part - {1'b0, radix};
      end
      rem_w = part[RADIX_W-1:0];
    end
  end

  assign quo_next = {quo[23:0], qbyte};
  assign load_ok  = !out_valid || !out_stall;

  // Status towards the controller
  always_comb begin
    stat.cfg_pending = pending;
    stat.base_ok     = ok;
    stat.chk_last    = !ok || (chk_idx == (radix - 6'd1));
    stat.div_last    = (bcnt == 2'd3) && (quo_next == '0);
    stat.emit_last   = load_ok && !neg_pend && (cnt == 6'd1);
  end

  // Configuration registers; any write forces a fresh table check.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix   <= '0;
      pending <= 1'b0;
      for (int k = 0; k < SYM_WORDS; k++) sym_words[k] <= '0;
    end else begin
      if (cmd.chk_start) pending <= 1'b0;
      if (cfg_valid) begin
        pending <= 1'b1;
        if (cfg_index == REG_RADIX) begin
          radix <= cfg_data[RADIX_W-1:0];
        end else begin
          sym_words[cfg_index - 3'd1] <= cfg_data;
        end
      end
    end
  end

  // Table check, one symbol per cycle against a bitmap of symbols seen so far.
  always_ff @(posedge clk) begin
    if (rst) begin
      ok <= 1'b0;
    end else if (cmd.chk_start) begin
      ok <= (radix >= 6'd2) && (radix <= 6'(MAX_RADIX));
    end else if (cmd.chk_step && sym_bad) begin
      ok <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.chk_start) begin
      chk_idx <= '0;
      seen    <= '0;
    end else if (cmd.chk_step) begin
      chk_idx             <= chk_idx + 6'd1;
      seen[sym_rd[6:0]] <= 1'b1;
    end
  end

  // Divider and digit stack; digits are pushed least significant first.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo      <= mag;
      rem      <= '0;
      bcnt     <= '0;
      cnt      <= '0;
      neg_pend <= vin[VALUE_W-1];
    end else if (cmd.div_step) begin
      quo  <= quo_next;
      bcnt <= bcnt + 2'd1;
      if (bcnt == 2'd3) begin
        stack[cnt[STACK_IDX_W-1:0]] <= rem_w;
        cnt                          <= cnt + 6'd1;
        rem                          <= '0;
      end else begin
        rem <= rem_w;
      end
    end else if (cmd.emit_en && load_ok) begin
      if (neg_pend) begin
        neg_pend <= 1'b0;
      end else begin
        cnt <= cnt_m1;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_en && load_ok) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_en && load_ok) begin
      if (neg_pend) begin
        symbol <= MINUS_CHAR;
        last   <= 1'b0;
      end else begin
        symbol <= sym_rd;
        last   <= (cnt == 6'd1);
      end
    end
  end

endmodule

// ===== design/signed_int_to_radix_symbols.sv =====
// Top level of the signed integer to radix symbol converter.
`timescale 1ns / 1ps

// Converts each signed 32-bit word into its text in the configured radix, one
// symbol per output word: '-' for a negative value, then the digits most
// significant first, with last set on the final symbol. A base that is not
// valid (radix outside 2..56, or a used symbol that is a sign, not printable
// or repeated) turns every input word into nothing. After a configuration
// write the block checks the symbol table, one symbol per cycle, holding
// in_stall high meanwhile; a bad symbol ends the check early, and a radix
// out of range ends it at its first step.
// A write that lands during a check starts a fresh check once it ends.
// Per word the radix divider resolves eight quotient bits a cycle, so each
// digit takes a pass over all four bytes of the quotient. One word is worked
// on at a time; the next is accepted while the final symbol waits in the
// output register.
// cfg_ready is always high.
module signed_int_to_radix_symbols (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stis_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stis_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [stis_pkg::VALUE_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [stis_pkg::SYM_W-1:0]          symbol,
  output logic                                last
);
  import stis_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  // Sequencer
  stis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Registers, checker, divider and output stage
  stis_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .symbol    (symbol),
    .last      (last),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Every emitted symbol is a minus sign or a printable table entry.
  a_sym_printable: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((symbol == MINUS_CHAR) ||
                   ((symbol > LOW_CTRL) && (symbol < DEL_CHAR))))
    else $error("emitted symbol is not printable");

  // A minus sign always leads digits, so it never closes a word's text.
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (symbol == MINUS_CHAR)) |-> !last)
    else $error("minus sign marked as final symbol");

  // No input word is taken while a table check is owed.
  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !stat.cfg_pending)
    else $error("input accepted before symbol table check");

endmodule
